// ----- src/lpht_pkg.sv -----
// Shared constants and codes for the linear probing hash table.
package lpht_pkg;

  localparam int KEY_W = 32;
  localparam int VALUE_W = 32;
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W = 8;
  localparam int ENTRIES_W = 9;
  localparam int CFG_W = 9;
  localparam int HASH_W = 8;

  localparam int TABLE_DEPTH_DEFAULT = 256;
  localparam int TABLE_SIZE_RESET = 256;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// ----- src/lpht_remainder.sv -----
// Bit-serial restoring remainder unit that reduces a key hash modulo the table size.
module lpht_remainder #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [lpht_pkg::HASH_W-1:0]          dividend,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     divisor,
  output logic                                 done,
  output logic [$clog2(TABLE_DEPTH)-1:0]       rem
);

  localparam int SZ_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int STEP_W = $clog2(lpht_pkg::HASH_W + 1);

  logic                        busy;
  logic [STEP_W-1:0]           steps;
  logic [lpht_pkg::HASH_W-1:0] shreg;
  logic [SZ_W-1:0]             acc;
  logic [SZ_W-1:0]             acc_next;
  logic [SZ_W:0]               trial;

  always_comb begin
    trial = {acc, shreg[lpht_pkg::HASH_W-1]};
    if (trial >= {1'b0, divisor}) begin
      acc_next = SZ_W'(trial - {1'b0, divisor});
    end else begin
      acc_next = SZ_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(lpht_pkg::HASH_W);
        shreg <= dividend;
        acc <= '0;
      end else if (busy) begin
        acc <= acc_next;
        shreg <= shreg << 1;
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = IDX_W'(acc);

endmodule

// ----- src/lpht_store.sv -----
// Key and value memories of the hash table, one write and one registered read port.
module lpht_store #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
  input  logic [lpht_pkg::KEY_W-1:0]         wr_key,
  input  logic [lpht_pkg::VALUE_W-1:0]       wr_value,
  input  logic                               rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
  output logic [lpht_pkg::KEY_W-1:0]         rd_key,
  output logic [lpht_pkg::VALUE_W-1:0]       rd_value
);

  logic [lpht_pkg::KEY_W-1:0]   key_mem [TABLE_DEPTH];
  logic [lpht_pkg::VALUE_W-1:0] value_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

endmodule

// ----- src/linear_probe_hash_table.sv -----
// Top level of the linear probing hash table: operation sequencer and slot bookkeeping.
//
// One operation (insert, lookup or remove) is a transfer on the input channel; each
// produces exactly one result transfer on the output channel. The table size register
// is written through its own channel while the block is idle, and every write empties
// the table. After reset the table is empty and the size is 256 slots, or TABLE_DEPTH
// if that is smaller. The block works on one operation at a time and is not ready
// until it has finished. Hashing is done in the bit-serial remainder unit. Each insert
// probe checks only the used bits; each lookup or remove probe passes through a find
// and a compare state because of the registered key memory read. A lookup of a key at
// its home slot passes through the hash, find, compare and result states. A remove
// also walks the cluster behind the freed slot and re-inserts each entry, rehashing it
// and probing for a free slot, so its latency grows with cluster length. An insert to
// a full table or an unused op goes straight to the result state without hashing.
// The finished result is held in an output register; the next operation is accepted
// while it waits. If the receiver stalls, a second finished result waits inside the
// block until the output register is free.
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpht_pkg::CFG_W-1:0]          cfg_size,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lpht_pkg::OP_W-1:0]           op,
  input  logic [lpht_pkg::KEY_W-1:0]          key,
  input  logic [lpht_pkg::VALUE_W-1:0]        value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]       status,
  output logic [lpht_pkg::SLOT_W-1:0]         slot,
  output logic [lpht_pkg::VALUE_W-1:0]        found_value,
  output logic [lpht_pkg::ENTRIES_W-1:0]      entries
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SZ_W = $clog2(TABLE_DEPTH + 1);
  localparam int SZ_RESET = (TABLE_DEPTH < lpht_pkg::TABLE_SIZE_RESET) ?
                            TABLE_DEPTH : lpht_pkg::TABLE_SIZE_RESET;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_PUT = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_CMP = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;
  localparam logic [2:0] S_WREAD = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0]                        state;
  logic [SZ_W-1:0]                   sz;
  logic [SZ_W-1:0]                   count;
  logic [TABLE_DEPTH-1:0]            used;
  logic [lpht_pkg::OP_W-1:0]         cur_op;
  logic                              reins;
  logic [lpht_pkg::KEY_W-1:0]        wkey;
  logic [lpht_pkg::VALUE_W-1:0]      wval;
  logic [IDX_W-1:0]                  pos;
  logic [SZ_W-1:0]                   n;
  logic [IDX_W-1:0]                  nxt;
  logic [SZ_W-1:0]                   wn;
  logic [lpht_pkg::STATUS_W-1:0]     res_status;
  logic [IDX_W-1:0]                  res_slot;
  logic [lpht_pkg::VALUE_W-1:0]      res_fval;

  logic                              in_fire;
  logic                              rem_start;
  logic [lpht_pkg::HASH_W-1:0]       rem_dividend;
  logic                              rem_done;
  logic [IDX_W-1:0]                  home;
  logic [SZ_W-1:0]                   sz_cfg;
  logic                              wr_en;
  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  logic [lpht_pkg::KEY_W-1:0]        rd_key;
  logic [lpht_pkg::VALUE_W-1:0]      rd_value;

  function automatic logic [lpht_pkg::HASH_W-1:0] fold_key(
    input logic [lpht_pkg::KEY_W-1:0] k
  );
    logic [lpht_pkg::HASH_W-1:0] h;
    h = '0;
    for (int i = 0; i < lpht_pkg::KEY_W / lpht_pkg::HASH_W; i++) begin
      h = h ^ k[i*lpht_pkg::HASH_W +: lpht_pkg::HASH_W];
    end
    return h;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(
    input logic [IDX_W-1:0] p,
    input logic [SZ_W-1:0]  s
  );
    logic [SZ_W-1:0] t;
    t = SZ_W'(p) + SZ_W'(1);
    return (t == s) ? '0 : IDX_W'(t);
  endfunction

  assign cfg_ready = (state == S_IDLE);
  assign in_ready = (state == S_IDLE) && !cfg_valid;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    if (cfg_size == '0) begin
      sz_cfg = SZ_W'(1);
    end else if (32'(cfg_size) > 32'(TABLE_DEPTH)) begin
      sz_cfg = SZ_W'(TABLE_DEPTH);
    end else begin
      sz_cfg = SZ_W'(cfg_size);
    end
  end

  assign rem_start = (in_fire && (op == lpht_pkg::OP_LOOKUP || op == lpht_pkg::OP_REMOVE ||
                      (op == lpht_pkg::OP_INSERT && count < sz))) || (state == S_WREAD);
  assign rem_dividend = (state == S_WREAD) ? fold_key(rd_key) : fold_key(key);

  assign wr_en = (state == S_PUT) && (n != sz) && !used[pos];
  assign rd_en = ((state == S_FIND) && (n != sz) && used[pos]) ||
                 ((state == S_WALK) && (wn != sz) && used[nxt]);
  assign rd_addr = (state == S_WALK) ? nxt : pos;

  lpht_remainder #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_remainder (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .dividend(rem_dividend),
    .divisor (sz),
    .done    (rem_done),
    .rem     (home)
  );

  lpht_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_key  (wkey),
    .wr_value(wval),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_value(rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sz <= SZ_W'(SZ_RESET);
      count <= '0;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            sz <= sz_cfg;
            used <= '0;
            count <= '0;
          end else if (in_valid) begin
            cur_op <= op;
            wkey <= key;
            wval <= value;
            reins <= 1'b0;
            res_slot <= '0;
            res_fval <= '0;
            if (op == lpht_pkg::OP_INSERT && count >= sz) begin
              res_status <= lpht_pkg::ST_FULL;
              state <= S_RESULT;
            end else if (op == lpht_pkg::OP_INSERT || op == lpht_pkg::OP_LOOKUP ||
                         op == lpht_pkg::OP_REMOVE) begin
              state <= S_HASH;
            end else begin
              res_status <= lpht_pkg::ST_MISS;
              state <= S_RESULT;
            end
          end
        end
        S_HASH: begin
          if (rem_done) begin
            pos <= home;
            n <= '0;
            if (cur_op == lpht_pkg::OP_INSERT || reins) begin
              state <= S_PUT;
            end else begin
              state <= S_FIND;
            end
          end
        end
        S_PUT: begin
          if (n == sz) begin
            res_status <= lpht_pkg::ST_FULL;
            state <= S_RESULT;
          end else if (!used[pos]) begin
            used[pos] <= 1'b1;
            count <= count + SZ_W'(1);
            if (reins) begin
              nxt <= wrap_inc(nxt, sz);
              wn <= wn + SZ_W'(1);
              state <= S_WALK;
            end else begin
              res_status <= lpht_pkg::ST_OK;
              res_slot <= pos;
              state <= S_RESULT;
            end
          end else begin
            pos <= wrap_inc(pos, sz);
            n <= n + SZ_W'(1);
          end
        end
        S_FIND: begin
          if (n == sz || !used[pos]) begin
            res_status <= lpht_pkg::ST_MISS;
            state <= S_RESULT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_key == wkey) begin
            res_status <= lpht_pkg::ST_OK;
            res_slot <= pos;
            if (cur_op == lpht_pkg::OP_LOOKUP) begin
              res_fval <= rd_value;
              state <= S_RESULT;
            end else begin
              used[pos] <= 1'b0;
              count <= count - SZ_W'(1);
              nxt <= wrap_inc(pos, sz);
              wn <= SZ_W'(1);
              state <= S_WALK;
            end
          end else begin
            pos <= wrap_inc(pos, sz);
            n <= n + SZ_W'(1);
            state <= S_FIND;
          end
        end
        S_WALK: begin
          if (wn == sz || !used[nxt]) begin
            state <= S_RESULT;
          end else begin
            state <= S_WREAD;
          end
        end
        S_WREAD: begin
          wkey <= rd_key;
          wval <= rd_value;
          used[nxt] <= 1'b0;
          count <= count - SZ_W'(1);
          reins <= 1'b1;
          state <= S_HASH;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            status <= res_status;
            slot <= lpht_pkg::SLOT_W'(res_slot);
            found_value <= res_fval;
            entries <= lpht_pkg::ENTRIES_W'(count);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= sz)
    else $error("entry count exceeds the active table size");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted operation did not start");

  a_put_marks_used: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> used[$past(pos)])
    else $error("written slot not marked as used");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && res_status != lpht_pkg::ST_OK |-> res_slot == '0)
    else $error("failed operation reports a nonzero slot");
`endif

endmodule
